>>> src/assert_macros.svh
// Assertion macros for the checker module of the permission map.
// Depends on nothing; included by the files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/bpm_pkg.sv
// Types, sizes and codes of the block permission map.
// Depends on nothing; used by the top level and the checker of the block.
package bpm_pkg;

   localparam int BLOCK_SHIFT = 3;
   localparam int RECORD_BITS = 4;
   localparam int NUM_BLOCKS  = 512;
   localparam int FREE_RECORD = 0;

   localparam int ADDR_W   = 16;
   localparam int FIELD_W  = 4;
   localparam int COUNT_W  = 10;
   localparam int BLK_W    = $clog2(NUM_BLOCKS);
   localparam int MATCH_W  = (RECORD_BITS > FIELD_W) ? RECORD_BITS : FIELD_W;

   localparam logic [ADDR_W-1:0]      BLK_MASK    = ADDR_W'((1 << BLOCK_SHIFT) - 1);
   localparam logic [ADDR_W-1:0]      NUM_BLK_A   = ADDR_W'(NUM_BLOCKS);
   localparam logic [BLK_W-1:0]       LAST_BLOCK  = BLK_W'(NUM_BLOCKS - 1);
   localparam logic [RECORD_BITS-1:0] FREE_REC    = RECORD_BITS'(FREE_RECORD);

   typedef enum logic {
      OP_SET    = 1'b0,
      OP_CHANGE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ZERO_LEN  = 3'd1,
      ST_BAD_LEN   = 3'd2,
      ST_TABLE_END = 3'd3,
      ST_OUTSIDE   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SET,
      S_CHECK
   } state_type;

   typedef struct packed {
      op_type              operation;
      logic [ADDR_W-1:0]   base_address;
      logic [ADDR_W-1:0]   length_bytes;
      logic [FIELD_W-1:0]  new_record;
      logic [FIELD_W-1:0]  match_mask;
      logic [FIELD_W-1:0]  match_value;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [COUNT_W-1:0]  blocks_changed;
   } rsp_type;

endpackage

>>> src/bpm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the permission records of the block.
module bpm_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/block_permission_map_core.sv
// Top level of the block permission map: sequencer, walk datapath and record RAM.
// Depends on bpm_pkg and bpm_ram.
//
// Usage. A transaction is accepted at a rising edge with start high and busy low;
// req_item carries its fields. Operation set writes new_record into every block
// of a byte range; operation change walks forward from the base block and
// rewrites records while (record AND match_mask) equals match_value.
// Each transaction gives exactly one result on rsp_item, shown for one cycle
// with rsp_strobe high; the receiver cannot stall it.
// Sequence: the request is registered at acceptance and checked in the decode
// state, where length or range errors end it; a set then writes its blocks, up
// to the table end, and a change rewrites matching records, stopping at the first
// mismatch or at the table end; the result is registered as the walk ends. One record
// is visited per cycle by the shared block counter and the single RAM port pair.
// busy drops in the strobe cycle, so the next start can be taken there.
// region_base is written on the csr channel, which is always ready; the user
// must change it only while the block is idle, which the block does not enforce.
// After reset the block clears all NUM_BLOCKS records to the free value, one
// per cycle, with busy high.
module block_permission_map_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  bpm_pkg::req_type              req_item,
   output logic                          rsp_strobe,
   output bpm_pkg::rsp_type              rsp_item,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bpm_pkg::ADDR_W-1:0]    csr_data
);

   bpm_pkg::state_type                 state_ff, state_in;
   bpm_pkg::req_type                   req_ff, req_in;
   logic [bpm_pkg::BLK_W-1:0]          blk_ff, blk_in;
   logic [bpm_pkg::ADDR_W-1:0]         left_ff, left_in;
   logic [bpm_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   bpm_pkg::rsp_type                   rsp_ff, rsp_in;
   logic [bpm_pkg::ADDR_W-1:0]         region_base_ff;

   logic                               wr_en;
   logic [bpm_pkg::BLK_W-1:0]          wr_addr;
   logic [bpm_pkg::RECORD_BITS-1:0]    wr_data;
   logic [bpm_pkg::BLK_W-1:0]          rd_addr;
   logic [bpm_pkg::RECORD_BITS-1:0]    rd_data;

   logic                               accept;
   logic [bpm_pkg::ADDR_W:0]           diff;
   logic [bpm_pkg::ADDR_W-1:0]         blk_num;
   logic                               outside;
   logic [bpm_pkg::BLK_W-1:0]          first_blk;
   logic                               dec_error;
   bpm_pkg::status_type                dec_status;
   logic [bpm_pkg::BLK_W-1:0]          blk_next;
   logic                               at_last;
   logic                               rec_match;
   logic [bpm_pkg::RECORD_BITS-1:0]    new_rec;
   logic [bpm_pkg::MATCH_W-1:0]        mask_w;

   assign accept    = start && !busy;
   assign busy      = (state_ff != bpm_pkg::S_IDLE);
   assign csr_ready = 1'b1;
   assign blk_next  = blk_ff + 1'b1;
   assign at_last   = (blk_ff == bpm_pkg::LAST_BLOCK);
   assign new_rec   = bpm_pkg::RECORD_BITS'(req_ff.new_record);
   assign mask_w    = bpm_pkg::MATCH_W'(req_ff.match_mask)
                      & bpm_pkg::MATCH_W'({bpm_pkg::RECORD_BITS{1'b1}});
   assign rec_match = ((bpm_pkg::MATCH_W'(rd_data) & mask_w)
                       == bpm_pkg::MATCH_W'(req_ff.match_value));

   always_comb begin
      diff      = {1'b0, req_ff.base_address} - {1'b0, region_base_ff};
      blk_num   = diff[bpm_pkg::ADDR_W-1:0] >> bpm_pkg::BLOCK_SHIFT;
      outside   = diff[bpm_pkg::ADDR_W] || (blk_num >= bpm_pkg::NUM_BLK_A);
      first_blk = blk_num[bpm_pkg::BLK_W-1:0];
      dec_error  = 1'b1;
      dec_status = bpm_pkg::ST_OUTSIDE;
      if (req_ff.operation == bpm_pkg::OP_SET && req_ff.length_bytes == '0) begin
         dec_status = bpm_pkg::ST_ZERO_LEN;
      end else if (req_ff.operation == bpm_pkg::OP_SET
                   && (req_ff.length_bytes & bpm_pkg::BLK_MASK) != '0) begin
         dec_status = bpm_pkg::ST_BAD_LEN;
      end else if (!outside) begin
         dec_error  = 1'b0;
         dec_status = bpm_pkg::ST_OK;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpm_pkg::S_CLEAR: begin
            if (at_last) begin
               state_in = bpm_pkg::S_IDLE;
            end
         end
         bpm_pkg::S_IDLE: begin
            if (accept) begin
               state_in = bpm_pkg::S_DECODE;
            end
         end
         bpm_pkg::S_DECODE: begin
            if (dec_error) begin
               state_in = bpm_pkg::S_IDLE;
            end else if (req_ff.operation == bpm_pkg::OP_SET) begin
               state_in = bpm_pkg::S_SET;
            end else begin
               state_in = bpm_pkg::S_CHECK;
            end
         end
         bpm_pkg::S_SET: begin
            if (left_ff == bpm_pkg::ADDR_W'(1) || at_last) begin
               state_in = bpm_pkg::S_IDLE;
            end
         end
         bpm_pkg::S_CHECK: begin
            if (!rec_match || at_last) begin
               state_in = bpm_pkg::S_IDLE;
            end
         end
         default: state_in = bpm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_in        = req_ff;
      blk_in        = blk_ff;
      left_in       = left_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = blk_ff;
      wr_data       = new_rec;
      rd_addr       = blk_next;
      unique case (state_ff)
         bpm_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = bpm_pkg::FREE_REC;
            blk_in  = blk_next;
         end
         bpm_pkg::S_IDLE: begin
            if (accept) begin
               req_in = req_item;
            end
         end
         bpm_pkg::S_DECODE: begin
            blk_in   = first_blk;
            left_in  = req_ff.length_bytes >> bpm_pkg::BLOCK_SHIFT;
            count_in = '0;
            rd_addr  = first_blk;
            if (dec_error) begin
               rsp_strobe_in         = 1'b1;
               rsp_in.status         = dec_status;
               rsp_in.blocks_changed = '0;
            end
         end
         bpm_pkg::S_SET: begin
            wr_en    = 1'b1;
            blk_in   = blk_next;
            left_in  = left_ff - 1'b1;
            count_in = count_ff + 1'b1;
            if (left_ff == bpm_pkg::ADDR_W'(1)) begin
               rsp_strobe_in         = 1'b1;
               rsp_in.status         = bpm_pkg::ST_OK;
               rsp_in.blocks_changed = count_ff + 1'b1;
            end else if (at_last) begin
               rsp_strobe_in         = 1'b1;
               rsp_in.status         = bpm_pkg::ST_TABLE_END;
               rsp_in.blocks_changed = count_ff + 1'b1;
            end
         end
         bpm_pkg::S_CHECK: begin
            if (rec_match) begin
               wr_en    = 1'b1;
               blk_in   = blk_next;
               count_in = count_ff + 1'b1;
               if (at_last) begin
                  rsp_strobe_in         = 1'b1;
                  rsp_in.status         = bpm_pkg::ST_TABLE_END;
                  rsp_in.blocks_changed = count_ff + 1'b1;
               end
            end else begin
               rsp_strobe_in         = 1'b1;
               rsp_in.status         = bpm_pkg::ST_OK;
               rsp_in.blocks_changed = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bpm_pkg::S_CLEAR;
         blk_ff         <= '0;
         rsp_strobe_ff  <= 1'b0;
         region_base_ff <= '0;
      end else begin
         state_ff      <= state_in;
         blk_ff        <= blk_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            region_base_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      left_ff  <= left_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   bpm_ram #(
      .WIDTH (bpm_pkg::RECORD_BITS),
      .DEPTH (bpm_pkg::NUM_BLOCKS)
   ) u_records (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

>>> src/bpm_checker.sv
// Port-level checker for the block permission map, bound to the top level.
// Depends on bpm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input bpm_pkg::rsp_type           rsp_item,
   input logic                       rsp_strobe
);

   // A result ends the transaction, so the block is free while it is shown.
   `ASSERT_SAME(a_strobe_not_busy, clock, reset, rsp_strobe, !busy)

   // An accepted transaction keeps the block busy in the following cycle.
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // Results never come in consecutive cycles.
   `ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe)

   // Rejected transactions write no record and report zero changed blocks.
   `ASSERT_SAME(a_reject_no_count, clock, reset,
      rsp_strobe && (rsp_item.status == bpm_pkg::ST_ZERO_LEN
                     || rsp_item.status == bpm_pkg::ST_BAD_LEN
                     || rsp_item.status == bpm_pkg::ST_OUTSIDE),
      rsp_item.blocks_changed == '0)

endmodule

bind block_permission_map_core bpm_checker u_bpm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_item   (rsp_item),
   .rsp_strobe (rsp_strobe)
);
